/* rtl/quicksort_sorter_core_macros.svh */
// Assertion macros shared by the quicksort sorter RTL.
`ifndef QUICKSORT_SORTER_CORE_MACROS_SVH
`define QUICKSORT_SORTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on i_clk, quiet while reset is low.
`define QSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quicksort_sorter_core: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, quiet while reset is low.
`define QSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quicksort_sorter_core: next-cycle check failed");

`else

`define QSC_ASSERT_IMPL(label, ante, cons)
`define QSC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/qsort_pkg.sv */
// Shared constants, control word types and microcode ROM of the quicksort sorter.
package qsort_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;
    localparam int CNT_W         = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Step counter and step labels
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_LOAD      = 5'd0;
    localparam t_step S_INIT      = 5'd1;
    localparam t_step S_POP       = 5'd2;
    localparam t_step S_RANGE     = 5'd3;
    localparam t_step S_PIVOT     = 5'd4;
    localparam t_step S_SCAN_I    = 5'd5;
    localparam t_step S_SCAN_J    = 5'd6;
    localparam t_step S_SWAP_I    = 5'd7;
    localparam t_step S_SWAP_J    = 5'd8;
    localparam t_step S_LOOP      = 5'd9;
    localparam t_step S_PUSH_R    = 5'd10;
    localparam t_step S_PUSH_L    = 5'd11;
    localparam t_step S_OUT_START = 5'd12;
    localparam t_step S_OUT_LOAD  = 5'd13;
    localparam t_step S_OUT_WAIT  = 5'd14;
    localparam t_step S_OUT_NEXT  = 5'd15;
    localparam t_step S_DONE      = 5'd16;

    // What to do when the jump condition is false
    localparam logic FALL_STAY = 1'b0;
    localparam logic FALL_NEXT = 1'b1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_POP,
        OP_RANGE,
        OP_PIVOT,
        OP_SCAN_I,
        OP_SCAN_J,
        OP_SWAP_I,
        OP_SWAP_J,
        OP_LOOP,
        OP_PUSH_R,
        OP_PUSH_L,
        OP_OUT_START,
        OP_OUT_LOAD,
        OP_OUT_WAIT,
        OP_DONE
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_LAST,
        C_FEW,
        C_SP_ZERO,
        C_SCAN_I,
        C_SCAN_J,
        C_BREAK,
        C_LOOP,
        C_OUT_ACC,
        C_MORE
    } t_cond;

    typedef struct packed {
        logic  in_rdy;
        t_op   op;
        t_cond cond;
        logic  fall;
        t_step target;
    } t_cw;

    // Microcode ROM: one control word per step
    function automatic t_cw ucode(input t_step s);
        t_cw w;
        case (s)
            S_LOAD:      w = '{1'b1, OP_LOAD,      C_IN_LAST, FALL_STAY, S_INIT};
            S_INIT:      w = '{1'b0, OP_INIT,      C_FEW,     FALL_NEXT, S_OUT_START};
            S_POP:       w = '{1'b0, OP_POP,       C_SP_ZERO, FALL_NEXT, S_OUT_START};
            S_RANGE:     w = '{1'b0, OP_RANGE,     C_NEVER,   FALL_NEXT, S_LOAD};
            S_PIVOT:     w = '{1'b0, OP_PIVOT,     C_NEVER,   FALL_NEXT, S_LOAD};
            S_SCAN_I:    w = '{1'b0, OP_SCAN_I,    C_SCAN_I,  FALL_NEXT, S_SCAN_I};
            S_SCAN_J:    w = '{1'b0, OP_SCAN_J,    C_SCAN_J,  FALL_NEXT, S_SCAN_J};
            S_SWAP_I:    w = '{1'b0, OP_SWAP_I,    C_BREAK,   FALL_NEXT, S_PUSH_R};
            S_SWAP_J:    w = '{1'b0, OP_SWAP_J,    C_NEVER,   FALL_NEXT, S_LOAD};
            S_LOOP:      w = '{1'b0, OP_LOOP,      C_LOOP,    FALL_NEXT, S_SCAN_I};
            S_PUSH_R:    w = '{1'b0, OP_PUSH_R,    C_NEVER,   FALL_NEXT, S_LOAD};
            S_PUSH_L:    w = '{1'b0, OP_PUSH_L,    C_ALWAYS,  FALL_NEXT, S_POP};
            S_OUT_START: w = '{1'b0, OP_OUT_START, C_NEVER,   FALL_NEXT, S_LOAD};
            S_OUT_LOAD:  w = '{1'b0, OP_OUT_LOAD,  C_NEVER,   FALL_NEXT, S_LOAD};
            S_OUT_WAIT:  w = '{1'b0, OP_OUT_WAIT,  C_OUT_ACC, FALL_STAY, S_OUT_NEXT};
            S_OUT_NEXT:  w = '{1'b0, OP_NONE,      C_MORE,    FALL_NEXT, S_OUT_LOAD};
            S_DONE:      w = '{1'b0, OP_DONE,      C_ALWAYS,  FALL_NEXT, S_LOAD};
            default:     w = '{1'b0, OP_NONE,      C_ALWAYS,  FALL_STAY, S_LOAD};
        endcase
        return w;
    endfunction

endpackage

/* rtl/quicksort_sorter_core.sv */
// Quicksort sorter top level: load, microcoded in-place sort, sorted read-out.
// Sequence: loading accepts one beat per cycle while i_valid is high; each popped range then
//   runs pop, range, pivot, scan-i, scan-j, swap and loop steps until its indices meet or cross.
// Read-out: one beat is presented at a time and held until i_ready takes it; the sort is bound
//   by the single read port of the element RAM.
// Reset: i_rst_n is synchronous, active low; it clears the step counter, counts and flags only.
`include "quicksort_sorter_core_macros.svh"

module quicksort_sorter_core #(
    parameter int DEPTH = qsort_pkg::DEPTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [qsort_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_last,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [qsort_pkg::VALUE_W-1:0] o_value_res,
    output logic                                o_last_res,
    output logic [qsort_pkg::CNT_W-1:0]         o_compare_count,
    output logic [qsort_pkg::CNT_W-1:0]         o_swap_count,
    output logic                                o_overflow
);

    localparam int AW = $clog2(DEPTH);       // element / stack address width
    localparam int CW = $clog2(DEPTH + 1);   // counts that may reach DEPTH
    localparam int IW = AW + 2;              // signed scan indices, span -1 .. DEPTH
    localparam int SW = 2 * AW;              // one stacked range: {lo, hi}
    localparam int VW = qsort_pkg::VALUE_W;
    localparam int NW = qsort_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    // ------------------------------------------------------------------
    // Sequencer: step counter, control word from the ROM, jump logic
    // ------------------------------------------------------------------
    qsort_pkg::t_step r_pc, n_pc;
    qsort_pkg::t_cw   cw;
    logic             c_take;

    // Run state (control, reset)
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_sp,  n_sp;
    logic [CW-1:0] r_k,   n_k;
    logic [NW-1:0] r_scan, n_scan;
    logic [NW-1:0] r_swap, n_swap;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;

    // Datapath payload (no reset)
    logic [AW-1:0]        r_lo, n_lo;
    logic [AW-1:0]        r_hi, n_hi;
    logic signed [IW-1:0] r_i, n_i;
    logic signed [IW-1:0] r_j, n_j;
    logic signed [VW-1:0] r_piv, n_piv;
    logic signed [VW-1:0] r_ai, n_ai;
    logic signed [VW-1:0] r_aj, n_aj;
    logic signed [VW-1:0] r_out_value, n_out_value;
    logic                 r_out_last, n_out_last;

    // RAM ports
    logic          e_we, e_re;
    logic [AW-1:0] e_waddr, e_raddr;
    logic [VW-1:0] e_wdata, e_rdata;
    logic          s_we, s_re;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [SW-1:0] s_wdata, s_rdata;

    // Derived datapath values
    logic                 in_acc, out_acc;
    logic signed [VW-1:0] e_rd_s;
    logic signed [IW-1:0] lo_s, hi_s, i_inc, j_dec;
    logic [AW-1:0]        srd_lo, srd_hi, mid;
    logic [AW:0]          mid_sum;
    logic [CW-1:0]        cnt_m1, sp_m1, k_inc;
    logic                 c_scan_i, c_scan_j, c_break, c_loop;

    function automatic logic [NW-1:0] bump(input logic [NW-1:0] c);
        return (c == qsort_pkg::CNT_MAX) ? c : c + 1'b1;
    endfunction

    assign cw      = qsort_pkg::ucode(r_pc);
    assign in_acc  = i_valid & cw.in_rdy;
    assign out_acc = r_out_valid & i_ready;

    assign e_rd_s  = e_rdata;
    assign lo_s    = {2'b00, r_lo};
    assign hi_s    = {2'b00, r_hi};
    assign i_inc   = r_i + IW'(1);
    assign j_dec   = r_j - IW'(1);
    assign srd_lo  = s_rdata[SW-1:AW];
    assign srd_hi  = s_rdata[AW-1:0];
    assign mid_sum = {1'b0, srd_lo} + {1'b0, srd_hi};
    assign mid     = mid_sum[AW:1];
    assign cnt_m1  = r_cnt - 1'b1;
    assign sp_m1   = r_sp - 1'b1;
    assign k_inc   = r_k + 1'b1;

    // Scan tests: keep advancing i past smaller values, j past larger ones
    assign c_scan_i = (r_i < hi_s) && (e_rd_s < r_piv);
    assign c_scan_j = (r_j > lo_s) && (e_rd_s > r_piv);
    assign c_break  = r_i > r_j;
    assign c_loop   = r_i < r_j;

    always_comb begin
        case (cw.cond)
            qsort_pkg::C_NEVER:   c_take = 1'b0;
            qsort_pkg::C_ALWAYS:  c_take = 1'b1;
            qsort_pkg::C_IN_LAST: c_take = in_acc & i_last;
            qsort_pkg::C_FEW:     c_take = r_cnt < TWO_C;
            qsort_pkg::C_SP_ZERO: c_take = r_sp == '0;
            qsort_pkg::C_SCAN_I:  c_take = c_scan_i;
            qsort_pkg::C_SCAN_J:  c_take = c_scan_j;
            qsort_pkg::C_BREAK:   c_take = c_break;
            qsort_pkg::C_LOOP:    c_take = c_loop;
            qsort_pkg::C_OUT_ACC: c_take = out_acc;
            qsort_pkg::C_MORE:    c_take = r_k < r_cnt;
            default:              c_take = 1'b0;
        endcase
    end

    always_comb begin
        if (c_take) begin
            n_pc = cw.target;
        end else if (cw.fall == qsort_pkg::FALL_NEXT) begin
            n_pc = qsort_pkg::t_step'(r_pc + 1'b1);
        end else begin
            n_pc = r_pc;
        end
    end

    // ------------------------------------------------------------------
    // Datapath: each op drives the RAM ports and register updates
    // ------------------------------------------------------------------
    always_comb begin
        n_cnt       = r_cnt;
        n_sp        = r_sp;
        n_k         = r_k;
        n_scan      = r_scan;
        n_swap      = r_swap;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_piv       = r_piv;
        n_ai        = r_ai;
        n_aj        = r_aj;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        e_we        = 1'b0;
        e_waddr     = '0;
        e_wdata     = '0;
        e_re        = 1'b0;
        e_raddr     = '0;
        s_we        = 1'b0;
        s_waddr     = '0;
        s_wdata     = '0;
        s_re        = 1'b0;
        s_raddr     = '0;

        case (cw.op)
            qsort_pkg::OP_LOAD: begin
                // store the beat, or drop it and flag overflow when full
                if (in_acc) begin
                    if (r_cnt < DEPTH_C) begin
                        e_we    = 1'b1;
                        e_waddr = r_cnt[AW-1:0];
                        e_wdata = i_value;
                        n_cnt   = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            qsort_pkg::OP_INIT: begin
                // push the whole set as the first range when it holds at least two elements
                if (r_cnt >= TWO_C) begin
                    s_we    = 1'b1;
                    s_waddr = r_sp[AW-1:0];
                    s_wdata = {AW'(0), cnt_m1[AW-1:0]};
                    n_sp    = r_sp + 1'b1;
                end
            end
            qsort_pkg::OP_POP: begin
                if (r_sp != '0) begin
                    s_re    = 1'b1;
                    s_raddr = sp_m1[AW-1:0];
                    n_sp    = sp_m1;
                end
            end
            qsort_pkg::OP_RANGE: begin
                n_lo    = srd_lo;
                n_hi    = srd_hi;
                n_i     = {2'b00, srd_lo};
                n_j     = {2'b00, srd_hi};
                e_re    = 1'b1;
                e_raddr = mid;
            end
            qsort_pkg::OP_PIVOT: begin
                n_piv   = e_rd_s;
                e_re    = 1'b1;
                e_raddr = r_i[AW-1:0];
            end
            qsort_pkg::OP_SCAN_I: begin
                e_re = 1'b1;
                if (c_scan_i) begin
                    n_i     = i_inc;
                    n_scan  = bump(r_scan);
                    e_raddr = i_inc[AW-1:0];
                end else begin
                    n_ai    = e_rd_s;
                    e_raddr = r_j[AW-1:0];
                end
            end
            qsort_pkg::OP_SCAN_J: begin
                if (c_scan_j) begin
                    n_j     = j_dec;
                    n_scan  = bump(r_scan);
                    e_re    = 1'b1;
                    e_raddr = j_dec[AW-1:0];
                end else begin
                    n_aj = e_rd_s;
                end
            end
            qsort_pkg::OP_SWAP_I: begin
                if (!c_break) begin
                    e_we    = 1'b1;
                    e_waddr = r_i[AW-1:0];
                    e_wdata = r_aj;
                    n_swap  = bump(r_swap);
                end
            end
            qsort_pkg::OP_SWAP_J: begin
                e_we    = 1'b1;
                e_waddr = r_j[AW-1:0];
                e_wdata = r_ai;
                n_i     = i_inc;
                n_j     = j_dec;
            end
            qsort_pkg::OP_LOOP: begin
                if (c_loop) begin
                    e_re    = 1'b1;
                    e_raddr = r_i[AW-1:0];
                end
            end
            qsort_pkg::OP_PUSH_R: begin
                if (r_i < hi_s) begin
                    s_we    = 1'b1;
                    s_waddr = r_sp[AW-1:0];
                    s_wdata = {r_i[AW-1:0], r_hi};
                    n_sp    = r_sp + 1'b1;
                end
            end
            qsort_pkg::OP_PUSH_L: begin
                if (lo_s < r_j) begin
                    s_we    = 1'b1;
                    s_waddr = r_sp[AW-1:0];
                    s_wdata = {r_lo, r_j[AW-1:0]};
                    n_sp    = r_sp + 1'b1;
                end
            end
            qsort_pkg::OP_OUT_START: begin
                n_k     = '0;
                e_re    = 1'b1;
                e_raddr = '0;
            end
            qsort_pkg::OP_OUT_LOAD: begin
                n_out_value = e_rd_s;
                n_out_last  = k_inc == r_cnt;
                n_out_valid = 1'b1;
                n_k         = k_inc;
            end
            qsort_pkg::OP_OUT_WAIT: begin
                // fetch the next element once the beat is taken
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    e_re        = 1'b1;
                    e_raddr     = r_k[AW-1:0];
                end
            end
            qsort_pkg::OP_DONE: begin
                n_cnt  = '0;
                n_sp   = '0;
                n_scan = '0;
                n_swap = '0;
                n_ovf  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= qsort_pkg::S_LOAD;
            r_cnt       <= '0;
            r_sp        <= '0;
            r_k         <= '0;
            r_scan      <= '0;
            r_swap      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_sp        <= n_sp;
            r_k         <= n_k;
            r_scan      <= n_scan;
            r_swap      <= n_swap;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_i         <= n_i;
        r_j         <= n_j;
        r_piv       <= n_piv;
        r_ai        <= n_ai;
        r_aj        <= n_aj;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    // ------------------------------------------------------------------
    // Element store and range stack
    // ------------------------------------------------------------------
    qsort_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (e_re),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    qsort_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign o_ready         = cw.in_rdy;
    assign o_valid         = r_out_valid;
    assign o_value_res     = r_out_value;
    assign o_last_res      = r_out_last;
    assign o_compare_count = r_scan;
    assign o_swap_count    = r_swap;
    assign o_overflow      = r_ovf;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `QSC_ASSERT_IMPL(a_no_load_during_readout, o_valid, !o_ready)
    `QSC_ASSERT_IMPL(a_stack_bounded, 1'b1, r_sp <= DEPTH_C)
    `QSC_ASSERT_IMPL(a_i_inside_range, r_pc == qsort_pkg::S_SCAN_J, r_i >= lo_s && r_i <= hi_s)
    `QSC_ASSERT_NEXT(a_last_beat_ends_set, out_acc && o_last_res, r_k == r_cnt)
    `QSC_ASSERT_NEXT(a_beat_taken_once, out_acc, !o_valid)

endmodule

/* rtl/qsort_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module qsort_ram #(
    parameter int WIDTH = qsort_pkg::VALUE_W,
    parameter int DEPTH = qsort_pkg::DEPTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
